// File: design/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// shared widths, codes and types of the adc to temperature linearizer
// ----------------------------------------------------------------------------
package atl_pkg;

    // field widths
    localparam int CODE_W    = 10;
    localparam int IDX_IN_W  = 5;
    localparam int ORIGIN_W  = 8;
    localparam int STEP_W    = 6;
    localparam int COUNT_W   = 6;
    localparam int TEMP_W    = 18;
    localparam int STATUS_W  = 3;
    localparam int SEG_W     = 5;
    localparam int FRAC_W    = 8;

    // arithmetic widths
    localparam int DIFF_W    = CODE_W + 1;
    localparam int PROD_W    = DIFF_W + STEP_W + 1;
    localparam int MAG_W     = CODE_W + STEP_W;
    localparam int DVD_W     = MAG_W + FRAC_W + 1;
    localparam int DSR_W     = CODE_W + 1;

    // temperature limits in 1/256 degree
    localparam int TEMP_MAX  = 2 ** (TEMP_W - 1) - 1;
    localparam int TEMP_MIN  = -(2 ** (TEMP_W - 1));

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ORIGIN_W;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 32;

    // reset values of the configuration registers
    localparam logic signed [ORIGIN_W-1:0] ORIGIN_RST  = -8'sd55;
    localparam logic [STEP_W-1:0]          STEP_RST    = 6'd5;
    localparam logic [COUNT_W-1:0]         ENTRIES_RST = 6'd32;

    // operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSIDE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FLAT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT    = 3'd4;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } atl_div_stat_t;

endpackage

// File: design/atl_req_if.sv
// ----------------------------------------------------------------------------
// atl_req_if
// request channel: load or convert beats with valid/ready handshake
// ----------------------------------------------------------------------------
interface atl_req_if
    import atl_pkg::*;
();

    logic                valid;
    logic                ready;
    logic                op;
    logic [IDX_IN_W-1:0] entry_index;
    logic [CODE_W-1:0]   code;

    modport source (output valid, output op, output entry_index, output code, input ready);
    modport sink   (input valid, input op, input entry_index, input code, output ready);

endinterface

// File: design/atl_res_if.sv
// ----------------------------------------------------------------------------
// atl_res_if
// result channel: temperature beats with valid/ready handshake
// ----------------------------------------------------------------------------
interface atl_res_if
    import atl_pkg::*;
();

    logic                       valid;
    logic                       ready;
    logic signed [TEMP_W-1:0]   temperature;
    logic [STATUS_W-1:0]        status;
    logic [SEG_W-1:0]           segment;

    modport source (output valid, output temperature, output status, output segment,
                    input ready);
    modport sink   (input valid, input temperature, input status, input segment,
                    output ready);

endinterface

// File: design/adc_to_temperature_linearizer.sv
// ----------------------------------------------------------------------------
// adc_to_temperature_linearizer
// piecewise-linear adc code to temperature conversion over a loadable table
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                            beat
//  request   in    op, entry_index, code              load one entry or convert
//  result    out   temperature, status, segment       one per convert, none per load
//  config    in    cfg_we, cfg_index, cfg_wdata       register write, no read-back
//
//  a load is written into the table as it is accepted; a convert holds the block
//  from accept to next accept: accept, reads of the two end entries, a scan of
//  one entry per cycle (one fetch instead for a sample outside the table), the
//  product and base set-up steps, the divider steps plus a hand-over, then the
//  step that saturates and registers the beat; a flat segment skips the divider
//  request.ready is high only while the sequencer is idle
//  a finished result waits in the output register; a stalled result holds the
//  sequencer in its last step
//  reset clears control state only; the code table holds nothing until loaded
//
module adc_to_temperature_linearizer
    import atl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    atl_req_if.sink               request,
    atl_res_if.source             result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BASE_W = IDX_W + STEP_W + FRAC_W + 1;
    localparam int SUM_W = ((BASE_W > DVD_W + 1) ? BASE_W : DVD_W + 1) + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(TEMP_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(TEMP_MIN);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_LAST   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_FETCH1 = 4'd4;
    localparam logic [3:0] S_FETCH2 = 4'd5;
    localparam logic [3:0] S_PROD   = 4'd6;
    localparam logic [3:0] S_BASE   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    // configuration registers
    logic signed [ORIGIN_W-1:0] origin_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [COUNT_W-1:0]         entries_reg;

    // sequencer and working registers
    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    logic [CODE_W-1:0]          x_reg;
    logic [IDX_W-1:0]           last_idx_reg;
    logic [IDX_W-1:0]           seg_reg;
    logic [CODE_W-1:0]          y1_reg;
    logic [CODE_W-1:0]          y2_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DIFF_W-1:0]   dy_reg;
    logic signed [SUM_W-1:0]    base_reg;
    logic                       neg_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [TEMP_W-1:0]   out_temp_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [SEG_W-1:0]           out_seg_reg;

    // table port
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [IDX_W-1:0]           mem_raddr;
    logic [CODE_W-1:0]          mem_rdata;

    // divider port
    logic                       div_start;
    logic [DVD_W-1:0]           div_dividend;
    logic [DSR_W-1:0]           div_divisor;
    logic [DVD_W-1:0]           div_quotient;
    atl_div_stat_t              div_stat;

    // combinational helpers
    logic                       req_accept;
    logic                       is_load;
    logic [IDX_W-1:0]           last_idx_w;
    logic                       below_w;
    logic                       above_w;
    logic                       scan_more;
    logic signed [DIFF_W-1:0]   diff_w;
    logic signed [DIFF_W-1:0]   dy_w;
    logic signed [STEP_W:0]     step_s;
    logic [IDX_W+STEP_W-1:0]    seg_step;
    logic [PROD_W-1:0]          prod_abs;
    logic [DIFF_W-1:0]          dy_abs;
    logic signed [SUM_W-1:0]    q_term;
    logic signed [SUM_W-1:0]    t_sum;
    logic                       sat_hi;
    logic                       sat_lo;
    logic                       out_free;

    assign req_accept = request.valid & request.ready;
    assign is_load    = (request.op == OP_LOAD);
    assign out_free   = ~out_valid_reg | result.ready;

    // ------------------------------------------------------------------------
    // configuration writes; unknown indexes fall through
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= ORIGIN_RST;
            step_reg    <= STEP_RST;
            entries_reg <= ENTRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN:  origin_reg  <= cfg_wdata;
                REG_STEP:    step_reg    <= cfg_wdata[STEP_W-1:0];
                REG_ENTRIES: entries_reg <= cfg_wdata[COUNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // entry count clamped to 2 .. TABLE_DEPTH, kept as index of last entry
    always_comb
    begin
        if (entries_reg < COUNT_W'(2))
        begin
            last_idx_w = IDX_W'(1);
        end
        else if (32'(entries_reg) > TABLE_DEPTH)
        begin
            last_idx_w = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx_w = IDX_W'(entries_reg - COUNT_W'(1));
        end
    end

    // ------------------------------------------------------------------------
    // code table; loads beyond the table depth are dropped
    // ------------------------------------------------------------------------
    assign mem_we    = req_accept & is_load & (32'(request.entry_index) < TABLE_DEPTH);
    assign mem_waddr = IDX_W'(request.entry_index);

    atl_code_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_code_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (request.code),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // segment decisions on the word just read
    assign below_w   = (x_reg < y1_reg);
    assign above_w   = (x_reg >= mem_rdata);
    assign scan_more = (IDX_W'(seg_reg + 1'b1) != last_idx_reg) && (x_reg >= mem_rdata);

    // read address: entry 0 while idle, then last entry, then the walk
    always_comb
    begin
        case (state_reg)
            S_IDLE:  mem_raddr = '0;
            S_FIRST: mem_raddr = last_idx_reg;
            S_LAST:
            begin
                if (!below_w && above_w)
                begin
                    mem_raddr = last_idx_reg - 1'b1;
                end
                else
                begin
                    mem_raddr = IDX_W'(1);
                end
            end
            S_SCAN:  mem_raddr = IDX_W'(seg_reg + 2'd2);
            default: mem_raddr = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // interpolation arithmetic
    // ------------------------------------------------------------------------
    assign diff_w   = $signed({1'b0, x_reg}) - $signed({1'b0, y1_reg});
    assign dy_w     = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
    assign step_s   = $signed({1'b0, step_reg});
    assign seg_step = seg_reg * step_reg;

    // rounding to nearest, ties away from zero: (2|num| + |dy|) / (2|dy|)
    assign prod_abs     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign dy_abs       = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    assign div_dividend = {prod_abs[MAG_W-1:0], {(FRAC_W + 1){1'b0}}} + DVD_W'(dy_abs);
    assign div_divisor  = {dy_abs[DIFF_W-2:0], 1'b0};
    assign div_start    = (state_reg == S_BASE) && (dy_reg != '0);

    atl_div_unit u_div_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // flat segment adds nothing to the lower entry temperature
    always_comb
    begin
        if (status_reg == ST_FLAT)
        begin
            q_term = '0;
        end
        else if (neg_reg)
        begin
            q_term = -$signed(SUM_W'(div_quotient));
        end
        else
        begin
            q_term = $signed(SUM_W'(div_quotient));
        end
    end

    assign t_sum  = base_reg + q_term;
    assign sat_hi = (t_sum > SAT_HI);
    assign sat_lo = (t_sum < SAT_LO);

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept && !is_load)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST: state_next = S_LAST;
            S_LAST:
            begin
                if (below_w)
                begin
                    state_next = S_FETCH2;
                end
                else if (above_w)
                begin
                    state_next = S_FETCH1;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = S_PROD;
                end
            end
            S_FETCH1: state_next = S_PROD;
            S_FETCH2: state_next = S_PROD;
            S_PROD:   state_next = S_BASE;
            S_BASE:   state_next = (dy_reg == '0) ? S_FIN : S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg        <= request.code;
                last_idx_reg <= last_idx_w;
            end
            S_FIRST: y1_reg <= mem_rdata;
            S_LAST:
            begin
                if (below_w)
                begin
                    seg_reg    <= '0;
                    status_reg <= ST_BELOW;
                end
                else if (above_w)
                begin
                    seg_reg    <= last_idx_reg - 1'b1;
                    y2_reg     <= mem_rdata;
                    status_reg <= ST_ABOVE;
                end
                else
                begin
                    seg_reg    <= '0;
                    status_reg <= ST_INSIDE;
                end
            end
            S_SCAN:
            begin
                if (scan_more)
                begin
                    y1_reg  <= mem_rdata;
                    seg_reg <= seg_reg + 1'b1;
                end
                else
                begin
                    y2_reg <= mem_rdata;
                end
            end
            S_FETCH1: y1_reg <= mem_rdata;
            S_FETCH2: y2_reg <= mem_rdata;
            S_PROD:
            begin
                prod_reg <= diff_w * step_s;
                dy_reg   <= dy_w;
            end
            S_BASE:
            begin
                base_reg <= (SUM_W'(origin_reg) <<< FRAC_W)
                          + SUM_W'({seg_step, {FRAC_W{1'b0}}});
                neg_reg  <= prod_reg[PROD_W-1] ^ dy_reg[DIFF_W-1];
                if (dy_reg == '0)
                begin
                    status_reg <= ST_FLAT;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // output register, saturation on the way in
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && out_free)
        begin
            out_seg_reg <= SEG_W'(seg_reg);
            if (sat_hi)
            begin
                out_temp_reg <= TEMP_W'(SAT_HI);
            end
            else if (sat_lo)
            begin
                out_temp_reg <= TEMP_W'(SAT_LO);
            end
            else
            begin
                out_temp_reg <= TEMP_W'(t_sum);
            end
            if ((sat_hi || sat_lo) && status_reg != ST_FLAT)
            begin
                out_status_reg <= ST_SAT;
            end
            else
            begin
                out_status_reg <= status_reg;
            end
        end
    end

    assign request.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.temperature = out_temp_reg;
    assign result.status      = out_status_reg;
    assign result.segment     = out_seg_reg;

`ifndef SYNTHESIS
    // a result beat appears only out of the final step
    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result beat raised outside final step");

    // the scanned segment never reaches the last entry in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> seg_reg < last_idx_reg)
        else $error("segment scan past last entry");

    // the divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide step");

    // a pending result is never overwritten before it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_temp_reg))
        else $error("pending result lost");
`endif

endmodule

// File: design/atl_code_mem.sv
// ----------------------------------------------------------------------------
// atl_code_mem
// table of adc codes, one write port and one registered read port
// ----------------------------------------------------------------------------
module atl_code_mem
    import atl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [CODE_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [CODE_W-1:0] rdata
);

    logic [CODE_W-1:0] mem [TABLE_DEPTH];
    logic [CODE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/atl_div_unit.sv
// ----------------------------------------------------------------------------
// atl_div_unit
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module atl_div_unit
    import atl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output atl_div_stat_t    stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   trial;
    logic             take;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DVD_W-1]};
        trial  = rem_sh - {1'b0, dsr_reg};
        take   = ~trial[DSR_W];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], take};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: dv/adc_to_temperature_linearizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_temperature_linearizer_tb
// self-checking bench: loads code tables, converts samples and checks every
// result beat against an in-bench interpolation predictor, under several
// register settings and with random idling on both channels
// ----------------------------------------------------------------------------
module adc_to_temperature_linearizer_tb;
    import atl_pkg::*;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    // settle margin covering the longest convert over the deepest table, twice over
    localparam int SETTLE_CYCLES  = 2 * (TABLE_DEPTH_DEF + 31);
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 90;

    // idling patterns applied per phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // shapes of the code table loaded at the start of a phase
    typedef enum int {
        SHAPE_RISING,
        SHAPE_STEPPED,
        SHAPE_FALLING,
        SHAPE_STEEP,
        SHAPE_SCRAMBLED
    } table_shape_t;

    typedef struct packed {
        logic                op;
        logic [IDX_IN_W-1:0] entry_index;
        logic [CODE_W-1:0]   code;
    } table_request_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [STATUS_W-1:0]      status;
        logic [SEG_W-1:0]         segment;
    } reading_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                req_valid = 1'b0;
    logic                req_op    = OP_CONVERT;
    logic [IDX_IN_W-1:0] req_index = '0;
    logic [CODE_W-1:0]   req_code  = '0;
    logic                res_ready = 1'b0;

    atl_req_if req_ch ();
    atl_res_if res_ch ();

    assign req_ch.valid       = req_valid;
    assign req_ch.op          = req_op;
    assign req_ch.entry_index = req_index;
    assign req_ch.code        = req_code;
    assign res_ch.ready       = res_ready;

    adc_to_temperature_linearizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .request   (req_ch),
        .result    (res_ch)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    table_request_t queued_requests[$];     // beats waiting for the driver
    reading_t       predicted_readings[$];  // results owed by the block, oldest first

    // predictor copy of the registers and the code table
    logic signed [ORIGIN_W-1:0] lin_origin  = ORIGIN_RST;
    logic [STEP_W-1:0]          lin_step    = STEP_RST;
    logic [COUNT_W-1:0]         lin_entries = ENTRIES_RST;
    logic [CODE_W-1:0]          lin_table [TABLE_DEPTH_DEF];

    // table as queued by the stimulus, used to aim samples near entries
    int plan_table [TABLE_DEPTH_DEF];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    logic request_taken = 1'b0;   // request beat accepted at the last rising edge
    int   stalled_cycles = 0;

    int mismatch_count     = 0;
    int readings_checked   = 0;
    int loads_done         = 0;
    int registers_written  = 0;

    // ------------------------------------------------------------------------
    // predictor: segment search, interpolation with round half away from
    // zero, then saturation to the 18-bit range
    // ------------------------------------------------------------------------
    function automatic reading_t predict_reading(input logic [CODE_W-1:0] sample);
        int                  n;
        int                  seg;
        longint              x;
        longint              y1;
        longint              dy;
        longint              t;
        longint              num;
        longint              mag;
        longint              den;
        longint              q;
        logic [STATUS_W-1:0] st;
        reading_t            r;

        // entry count clamps to the usable range
        n = int'(lin_entries);
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH_DEF)
            n = TABLE_DEPTH_DEF;

        x = longint'(sample);
        if (x < longint'(lin_table[0]))
        begin
            seg = 0;
            st  = ST_BELOW;
        end
        else if (x >= longint'(lin_table[n-1]))
        begin
            seg = n - 2;
            st  = ST_ABOVE;
        end
        else
        begin
            // first pair whose upper entry lies above the sample
            seg = 0;
            while (seg < n - 2 && x >= longint'(lin_table[seg+1]))
                seg++;
            st = ST_INSIDE;
        end

        y1 = longint'(lin_table[seg]);
        dy = longint'(lin_table[seg+1]) - y1;
        t  = longint'(lin_origin) * 256 + longint'(seg) * longint'(lin_step) * 256;

        // a flat segment gives the lower entry temperature
        if (dy == 0)
            st = ST_FLAT;
        else
        begin
            num = (x - y1) * longint'(lin_step) * 256;
            mag = (num < 0) ? -num : num;
            den = (dy < 0) ? -dy : dy;
            q   = (mag * 2 + den) / (den * 2);
            t   = t + (((num < 0) != (dy < 0)) ? -q : q);
        end

        if (t > TEMP_MAX)
        begin
            t = TEMP_MAX;
            if (st != ST_FLAT)
                st = ST_SAT;
        end
        else if (t < TEMP_MIN)
        begin
            t = TEMP_MIN;
            if (st != ST_FLAT)
                st = ST_SAT;
        end

        r.temperature = t[TEMP_W-1:0];
        r.status      = st;
        r.segment     = seg[SEG_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // request driver: new beats appear at the falling edge, a presented beat
    // is held until the block takes it
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        table_request_t next_req;
        if (rst_n && (!req_valid || request_taken))
        begin
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_req  = queued_requests.pop_front();
                req_valid <= 1'b1;
                req_op    <= next_req.op;
                req_index <= next_req.entry_index;
                req_code  <= next_req.code;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        if (rst_n)
            res_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each accepted request beat, checks each accepted
    // result beat against the oldest prediction, and runs the watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        reading_t want;
        reading_t got;
        logic     moved;
        if (rst_n)
        begin
            moved = 1'b0;

            if (req_valid && req_ch.ready)
            begin
                moved = 1'b1;
                if (req_op == OP_LOAD)
                begin
                    lin_table[req_index] = req_code;
                    loads_done++;
                end
                else
                    predicted_readings.push_back(predict_reading(req_code));
            end

            if (res_ch.valid && res_ready)
            begin
                moved           = 1'b1;
                got.temperature = res_ch.temperature;
                got.status      = res_ch.status;
                got.segment     = res_ch.segment;
                if (predicted_readings.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, temperature %0d status %0d segment %0d",
                             $time, $signed(got.temperature), got.status, got.segment);
                end
                else
                begin
                    want = predicted_readings.pop_front();
                    readings_checked++;
                    check_field("temperature", longint'($signed(want.temperature)),
                                longint'($signed(got.temperature)));
                    check_field("status", longint'(want.status), longint'(got.status));
                    check_field("segment", longint'(want.segment), longint'(got.segment));
                end
            end

            request_taken <= req_valid && req_ch.ready;

            // no beat on either channel for too long means the block hung
            if (moved)
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                         $time, stalled_cycles, predicted_readings.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_load(input int idx, input int entry_code);
        table_request_t item;
        item.op          = OP_LOAD;
        item.entry_index = idx[IDX_IN_W-1:0];
        item.code        = entry_code[CODE_W-1:0];
        queued_requests.push_back(item);
        plan_table[idx] = entry_code;
    endtask

    // entry_index is don't-care for a convert, so it carries random bits
    task automatic queue_convert(input int sample);
        table_request_t item;
        item.op          = OP_CONVERT;
        item.entry_index = IDX_IN_W'($urandom_range(0, 31));
        item.code        = sample[CODE_W-1:0];
        queued_requests.push_back(item);
    endtask

    // sender drains, every owed result comes back, then the block gets time
    // to finish any load still in flight; registers may be written afterwards
    task automatic settle();
        while (queued_requests.size() != 0 || req_valid || predicted_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one write strobe, only ever issued while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] wdata);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        case (idx)
            REG_ORIGIN:  lin_origin  = wdata;
            REG_STEP:    lin_step    = wdata[STEP_W-1:0];
            REG_ENTRIES: lin_entries = wdata[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        registers_written++;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct    = 63;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 63;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct    = 16;
                receiver_stall_pct = 16;
            end
            default:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // one random phase: registers, a full table of the given shape, then
    // mostly conversions with a few stray entry rewrites
    task automatic run_phase(input idle_mode_t mode, input logic [CFG_DATA_W-1:0] origin,
                             input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] entries,
                             input table_shape_t shape);
        int i;
        int acc;
        int span;
        int sample;
        settle();
        write_register(REG_ORIGIN, origin);
        write_register(REG_STEP, step);
        write_register(REG_ENTRIES, entries);
        @(posedge clk);
        set_idling(mode);

        case (shape)
            SHAPE_RISING, SHAPE_STEPPED:
            begin
                // stepped tables repeat codes, so flat segments turn up
                acc  = $urandom_range(0, 200);
                span = (1023 - acc) / 31;
                for (i = 0; i < TABLE_DEPTH_DEF; i++)
                begin
                    queue_load(i, acc);
                    acc += $urandom_range((shape == SHAPE_STEPPED) ? 0 : 1, span);
                end
            end
            SHAPE_FALLING:
            begin
                acc  = $urandom_range(823, 1023);
                span = acc / 31;
                for (i = 0; i < TABLE_DEPTH_DEF; i++)
                begin
                    queue_load(i, acc);
                    acc -= $urandom_range(1, span);
                end
            end
            SHAPE_STEEP:
            begin
                // tiny code gaps give steep slopes and frequent saturation
                acc = $urandom_range(0, 900);
                for (i = 0; i < TABLE_DEPTH_DEF; i++)
                begin
                    queue_load(i, acc);
                    acc += $urandom_range(1, 3);
                end
            end
            default:
                for (i = 0; i < TABLE_DEPTH_DEF; i++)
                    queue_load(i, $urandom_range(0, 1023));
        endcase

        for (i = 0; i < ITEMS_PER_PHASE; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                queue_load($urandom_range(0, 31), $urandom_range(0, 1023));
            else if ($urandom_range(0, 99) < 55)
                queue_convert($urandom_range(0, 1023));
            else
            begin
                // aim at a table entry, a code or two either side
                sample = plan_table[$urandom_range(0, 31)] + $urandom_range(0, 4) - 2;
                if (sample < 0)
                    sample = 0;
                if (sample > 1023)
                    sample = 1023;
                queue_convert(sample);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int           i;
        int           p;
        idle_mode_t   mode;
        table_shape_t shape;
        logic [CFG_DATA_W-1:0] origin;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] entries;

        // reset held, then released once at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // -- directed: reset registers, evenly spaced rising table
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
            queue_load(i, i * 32 + 16);
        queue_convert(0);       // below the first entry
        queue_convert(16);      // exactly on the first entry
        queue_convert(100);
        queue_convert(520);
        queue_convert(1007);    // top of the last segment
        queue_convert(1008);    // exactly on the last entry, extrapolated
        queue_convert(1023);    // top code

        // hottest settings: the upper table saturates high
        settle();
        write_register(REG_ORIGIN, 8'd127);
        write_register(REG_STEP, 8'd32);
        write_register(REG_ENTRIES, 8'd32);
        @(posedge clk);
        queue_convert(1023);
        queue_convert(500);

        // coldest origin, two-entry table with a unit gap: both ends saturate;
        // an entry count of zero acts as two
        settle();
        write_register(REG_ORIGIN, 8'h80);
        write_register(REG_ENTRIES, 8'd0);
        @(posedge clk);
        queue_load(0, 1000);
        queue_load(1, 1001);
        queue_convert(0);
        queue_convert(1023);
        queue_convert(1000);
        // equal end entries: flat segment wins over below and above
        queue_load(1, 1000);
        queue_convert(500);
        queue_convert(1023);

        // zero step and a count of one, then a falling pair
        settle();
        write_register(REG_STEP, 8'd0);
        write_register(REG_ENTRIES, 8'd1);
        @(posedge clk);
        queue_convert(300);
        queue_load(1, 200);
        queue_convert(500);
        settle();
        write_register(REG_STEP, 8'd17);
        @(posedge clk);
        queue_convert(500);
        queue_convert(1010);

        // writes to the unused index change nothing; counts past the table
        // depth act as the full table
        settle();
        write_register(REG_SPARE, 8'hA5);
        write_register(REG_ENTRIES, 8'd33);
        @(posedge clk);
        queue_convert(640);
        settle();
        write_register(REG_ENTRIES, 8'd63);
        @(posedge clk);
        queue_convert(700);

        // -- random phases, idling pattern rotating through all four
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            mode    = idle_mode_t'(p % 4);
            origin  = CFG_DATA_W'($urandom_range(0, 255));
            step    = CFG_DATA_W'($urandom_range(1, 32));
            entries = CFG_DATA_W'($urandom_range(2, 32));
            case (p)
                0:
                begin
                    origin  = 8'h80;
                    step    = 8'd1;
                    entries = 8'd2;
                end
                1:
                begin
                    origin  = 8'd127;
                    step    = 8'd32;
                    entries = 8'd32;
                end
                2:
                begin
                    step    = 8'd0;
                    entries = 8'd1;
                end
                3:
                begin
                    step    = 8'd63;
                    entries = 8'd63;
                end
                default: ;
            endcase
            case (p)
                4:       shape = SHAPE_STEPPED;
                5:       shape = SHAPE_FALLING;
                6:       shape = SHAPE_SCRAMBLED;
                7:       shape = SHAPE_STEEP;
                9:       shape = SHAPE_STEPPED;
                default: shape = SHAPE_RISING;
            endcase
            run_phase(mode, origin, step, entries, shape);
        end

        // drain, then give late or stray beats time to show up
        settle();

        $display("covered %0d conversions and %0d table loads over %0d register writes",
                 readings_checked, loads_done, registers_written);
        $display("idling: none, sender only, receiver only and both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && predicted_readings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: adc_to_temperature_linearizer.f
design/atl_pkg.sv
design/atl_req_if.sv
design/atl_res_if.sv
design/atl_code_mem.sv
design/atl_div_unit.sv
design/adc_to_temperature_linearizer.sv
dv/adc_to_temperature_linearizer_tb.sv
